// ----- hdl/cia_pkg.sv -----
// Shared types, codes and widths for the checked integer ALU.
package cia_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int HalfWidth  = (DATA_WIDTH + 1) / 2;
	// Register stage whose output holds the finished product.
	localparam int MulDone    = 4;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_REM = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	typedef struct packed {
		op_t                           op;
		logic signed [DATA_WIDTH-1:0]  lhs;
		logic signed [DATA_WIDTH-1:0]  rhs;
	} req_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0]  answer;
		status_t                       status;
	} rsp_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] quo;
		logic [DATA_WIDTH-1:0] rem;
	} div_res_t;

	typedef struct packed {
		logic  valid;
		op_t   op;
		logic  neg_q;
		logic  neg_a;
		logic  div0;
		logic  min_m1;
		rsp_t  early;
	} ctl_t;

endpackage

// ----- hdl/cia_mul.sv -----
// Three-stage signed multiplier with range check on the full product.
module cia_mul import cia_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [DATA_WIDTH-1:0] ua,
	input  logic [DATA_WIDTH-1:0] ub,
	input  logic                  neg,
	output rsp_t                  res
);

	localparam int LoW = HalfWidth;
	localparam int HiW = DATA_WIDTH - HalfWidth;
	localparam int PW  = 2 * DATA_WIDTH;

	logic [2*LoW-1:0]   ll_s2;
	logic [LoW+HiW-1:0] lh_s2;
	logic [LoW+HiW-1:0] hl_s2;
	logic [2*HiW-1:0]   hh_s2;
	logic               neg_s2;
	logic [PW-1:0]      prod_s3;
	logic               neg_s3;
	rsp_t               res_s4;

	logic                  too_big;
	logic [DATA_WIDTH-1:0] mag;

	// The magnitude fits when the upper half is clear and, below that, it is at
	// most the largest positive value, or exactly the minimum when negative.
	assign mag     = prod_s3[DATA_WIDTH-1:0];
	assign too_big = (|prod_s3[PW-1:DATA_WIDTH]) ||
		(mag[DATA_WIDTH-1] && (!neg_s3 || (|mag[DATA_WIDTH-2:0])));

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s2   <= (2*LoW)'(ua[LoW-1:0]) * (2*LoW)'(ub[LoW-1:0]);
			lh_s2   <= (LoW+HiW)'(ua[LoW-1:0]) * (LoW+HiW)'(ub[DATA_WIDTH-1:LoW]);
			hl_s2   <= (LoW+HiW)'(ua[DATA_WIDTH-1:LoW]) * (LoW+HiW)'(ub[LoW-1:0]);
			hh_s2   <= (2*HiW)'(ua[DATA_WIDTH-1:LoW]) * (2*HiW)'(ub[DATA_WIDTH-1:LoW]);
			neg_s2  <= neg;
			prod_s3 <= PW'(ll_s2) + (PW'(lh_s2) << LoW) + (PW'(hl_s2) << LoW)
				+ (PW'(hh_s2) << (2 * LoW));
			neg_s3  <= neg_s2;
			if (too_big) begin
				res_s4.answer <= '0;
				res_s4.status <= ST_OVF;
			end else begin
				res_s4.answer <= neg_s3 ? (~mag + 1'b1) : mag;
				res_s4.status <= ST_OK;
			end
		end
	end

	assign res = res_s4;

endmodule

// ----- hdl/cia_div.sv -----
// Restoring divider on magnitudes, one quotient bit per pipeline stage.
module cia_div import cia_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [DATA_WIDTH-1:0] ua,
	input  logic [DATA_WIDTH-1:0] ub,
	output div_res_t              res
);

	localparam int W = DATA_WIDTH;

	// Entry k is the register after stage k; the dividend register fills with
	// quotient bits from the bottom as the dividend shifts out at the top.
	logic [W-1:0] rem_s [W];
	logic [W-1:0] dvd_s [W];
	logic [W-1:0] dsr_s [W];

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W-1:0] rem_in;
		logic [W-1:0] dvd_in;
		logic [W-1:0] dsr_in;
		logic [W:0]   trial;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign dvd_in = ua;
			assign dsr_in = ub;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign dvd_in = dvd_s[k-1];
			assign dsr_in = dsr_s[k-1];
		end

		assign trial = {rem_in, dvd_in[W-1]} - {1'b0, dsr_in};

		always_ff @(posedge clk) begin
			if (en) begin
				if (trial[W]) begin
					rem_s[k] <= {rem_in[W-2:0], dvd_in[W-1]};
				end else begin
					rem_s[k] <= trial[W-1:0];
				end
				dvd_s[k] <= {dvd_in[W-2:0], ~trial[W]};
				dsr_s[k] <= dsr_in;
			end
		end
	end

	assign res.quo = dvd_s[W-1];
	assign res.rem = rem_s[W-1];

endmodule

// ----- hdl/checked_integer_alu_core.sv -----
// Top level of the checked signed integer ALU pipeline.
//
// Each request carries an opcode and two signed operands; each response carries
// the signed answer and a status code (ok, overflow or divide by zero). Add and
// subtract are checked on their exact sum, multiply on its full product. Divide
// truncates toward zero and remainder takes the sign of the dividend. Whenever
// the status is not ok the answer is zero.
//
// Both channels use valid and stall. A request is taken on a clock edge with
// req_valid high and req_stall low; a response leaves the same way on the rsp
// side. Every request gives exactly one response, in order.
//
// A request passes the operand register, the DATA_WIDTH divider stages and the
// response register. The divider sets the length with one quotient bit per stage;
// the others ride along beside it. One request can enter every unstalled cycle.
//
// When the receiver stalls a valid response, the whole pipeline holds and
// req_stall rises in the same cycle, so nothing is dropped or repeated. Reset
// clears all valid bits; the block takes requests right after reset.
module checked_integer_alu_core import cia_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int W = DATA_WIDTH;

	logic en;

	logic [W:0]   sum;
	logic [W:0]   diff;
	logic [W-1:0] ua;
	logic [W-1:0] ub;
	ctl_t         ctl_in;

	logic [W-1:0] ua_s1;
	logic [W-1:0] ub_s1;
	ctl_t         ctl_s [1:W+1];
	ctl_t         ctl_mul;

	rsp_t         mul_res;
	div_res_t     div_res;
	logic [W-1:0] quo;
	logic [W-1:0] rmd;
	rsp_t         rsp_next;

	// The pipeline moves unless the response register holds a stalled response.
	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	// Front stage: exact add and subtract at one extra bit, magnitudes for the
	// multiplier and divider, and the special cases of division.
	assign sum  = {req.lhs[W-1], req.lhs} + {req.rhs[W-1], req.rhs};
	assign diff = {req.lhs[W-1], req.lhs} - {req.rhs[W-1], req.rhs};
	assign ua   = req.lhs[W-1] ? (~req.lhs + 1'b1) : req.lhs;
	assign ub   = req.rhs[W-1] ? (~req.rhs + 1'b1) : req.rhs;

	always_comb begin
		ctl_in.valid  = req_valid;
		ctl_in.op     = req.op;
		ctl_in.neg_q  = req.lhs[W-1] ^ req.rhs[W-1];
		ctl_in.neg_a  = req.lhs[W-1];
		ctl_in.div0   = (req.rhs == '0);
		ctl_in.min_m1 = (req.lhs == {1'b1, {(W-1){1'b0}}}) && (&req.rhs);
		ctl_in.early  = '{answer: '0, status: ST_OK};
		unique case (req.op)
			OP_ADD: begin
				if (sum[W] != sum[W-1]) begin
					ctl_in.early.status = ST_OVF;
				end else begin
					ctl_in.early.answer = sum[W-1:0];
				end
			end
			OP_SUB: begin
				if (diff[W] != diff[W-1]) begin
					ctl_in.early.status = ST_OVF;
				end else begin
					ctl_in.early.answer = diff[W-1:0];
				end
			end
			default: begin
				ctl_in.early = '{answer: '0, status: ST_OK};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ua_s1 <= ua;
			ub_s1 <= ub;
		end
	end

	cia_mul u_mul (
		.clk (clk),
		.en  (en),
		.ua  (ua_s1),
		.ub  (ub_s1),
		.neg (ctl_s[1].neg_q),
		.res (mul_res)
	);

	cia_div u_div (
		.clk (clk),
		.en  (en),
		.ua  (ua_s1),
		.ub  (ub_s1),
		.res (div_res)
	);

	// Back end: sign the divider's magnitudes and pick the response.
	assign quo = ctl_s[W+1].neg_q ? (~div_res.quo + 1'b1) : div_res.quo;
	assign rmd = ctl_s[W+1].neg_a ? (~div_res.rem + 1'b1) : div_res.rem;

	always_comb begin
		rsp_next = ctl_s[W+1].early;
		unique case (ctl_s[W+1].op)
			OP_DIV: begin
				priority if (ctl_s[W+1].div0) begin
					rsp_next = '{answer: '0, status: ST_DIV0};
				end else if (ctl_s[W+1].min_m1) begin
					rsp_next = '{answer: '0, status: ST_OVF};
				end else begin
					rsp_next = '{answer: quo, status: ST_OK};
				end
			end
			OP_REM: begin
				// The minimum over minus one leaves a zero remainder by itself.
				if (ctl_s[W+1].div0) begin
					rsp_next = '{answer: '0, status: ST_DIV0};
				end else begin
					rsp_next = '{answer: rmd, status: ST_OK};
				end
			end
			default: begin
				rsp_next = ctl_s[W+1].early;
			end
		endcase
	end

	// The product replaces the early response of a multiply as the request
	// leaves the multiplier's last stage.
	always_comb begin
		ctl_mul = ctl_s[MulDone];
		if (ctl_mul.op == OP_MUL) begin
			ctl_mul.early = mul_res;
		end
	end

	// Control line beside the datapath. The product joins it once the
	// multiplier has finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= W + 1; k++) begin
				ctl_s[k] <= '0;
			end
			rsp_valid <= 1'b0;
			rsp       <= '0;
		end else if (en) begin
			ctl_s[1] <= ctl_in;
			for (int k = 2; k <= W + 1; k++) begin
				ctl_s[k] <= (k == MulDone + 1) ? ctl_mul : ctl_s[k-1];
			end
			rsp_valid <= ctl_s[W+1].valid;
			rsp       <= rsp_next;
		end
	end

endmodule
